// File: hdl/palette_alpha_blend_blit_top_defines.svh
// ----------------------------------------------------------------------------
// Palette alpha blend blitter: assertion macros
// Shared concurrent assertion forms, clocked on aclk. Defining NO_ASSERTIONS
// turns every use into an empty statement.
// ----------------------------------------------------------------------------
`ifndef PALETTE_ALPHA_BLEND_BLIT_TOP_DEFINES_SVH
`define PALETTE_ALPHA_BLEND_BLIT_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Check prop at every edge outside reset.
`define PABB_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);
// Check prop at every edge, reset included.
`define PABB_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) (prop)) else $error(msg);
`else
`define PABB_ASSERT(label, prop, msg)
`define PABB_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

// File: hdl/pabb_pkg.sv
// ----------------------------------------------------------------------------
// Palette alpha blend blitter package
// Palette entry type, command and layout codes, register map and the
// per-channel blend function.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pabb_pkg;

    // Palette entry, red in the lowest byte
    typedef struct packed {
        logic [7:0] alpha;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } pal_entry_t;

    localparam int unsigned PAL_DEPTH = 256;
    localparam int unsigned PAL_AW    = 8;

    // Command carried in tuser
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_PIXEL = 1'b1;

    // channel_order codes; anything else leaves the destination unchanged
    localparam logic [1:0] ORDER_RGB = 2'd0;
    localparam logic [1:0] ORDER_BGR = 2'd1;

    // Register index of channel_order (byte address 4 * index)
    localparam logic REG_CHANNEL_ORDER = 1'b0;

    // Alpha that keeps the destination byte as it is
    localparam logic [7:0] ALPHA_KEEP_DEST = 8'd255;

    // Blend one channel: c + floor((d - c) * a / 256), kept to 8 bits.
    // Alpha 0 gives c and alpha 128 gives the floor average through the same
    // expression; only full transparency needs its own arm.
    function automatic logic [7:0] blend_channel(
        input logic [7:0] c,
        input logic [7:0] d,
        input logic [7:0] a
    );
        logic signed [8:0]  diff;
        logic signed [17:0] prod;
        logic [7:0]         res;
        diff = $signed({1'b0, d}) - $signed({1'b0, c});
        prod = diff * $signed({1'b0, a});
        if (a == ALPHA_KEEP_DEST) begin
            res = d;
        end else begin
            res = c + prod[15:8];
        end
        return res;
    endfunction

endpackage

// File: hdl/pabb_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data, held while
// the read enable is low.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pabb_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hdl/pabb_blend.sv
// ----------------------------------------------------------------------------
// Pixel blend
// Places the palette colour by channel order and blends it with the three
// destination bytes; an unsupported order passes the destination through.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pabb_blend (
    input  pabb_pkg::pal_entry_t entry,
    input  logic [23:0]          dest,      // byte0 [7:0], byte1 [15:8], byte2 [23:16]
    input  logic [1:0]           order,
    output logic [23:0]          result     // byte0 [7:0], byte1 [15:8], byte2 [23:16]
);

    logic [7:0] c0;
    logic [7:0] c2;
    logic       pass;

    // Pick the colour for the outer bytes
    always_comb begin
        c0   = entry.red;
        c2   = entry.blue;
        pass = 1'b0;
        unique case (order)
            pabb_pkg::ORDER_RGB: begin
                c0 = entry.red;
                c2 = entry.blue;
            end
            pabb_pkg::ORDER_BGR: begin
                c0 = entry.blue;
                c2 = entry.red;
            end
            default: begin
                pass = 1'b1;
            end
        endcase
    end

    // Blend each channel, green always in byte 1, or pass the destination through
    always_comb begin
        if (pass) begin
            result = dest;
        end else begin
            result[7:0]   = pabb_pkg::blend_channel(c0, dest[7:0], entry.alpha);
            result[15:8]  = pabb_pkg::blend_channel(entry.green, dest[15:8], entry.alpha);
            result[23:16] = pabb_pkg::blend_channel(c2, dest[23:16], entry.alpha);
        end
    end

endmodule

// File: hdl/palette_alpha_blend_blit_top.sv
// ----------------------------------------------------------------------------
// Palette alpha blend blitter, top level
// Indexed-colour blender with a 256-entry RGBA palette and an APB register.
// ----------------------------------------------------------------------------
// The block takes one transfer per clock while s_tready is high, loads and
// pixels mixed freely. A load (tuser 0) writes one palette entry and gives no
// result; a pixel (tuser 1) gives one result, passing through the registered
// palette RAM read and then the blend into the output register.
// The palette has no reset and no clearing pass: a pixel must only use an
// entry loaded since reset. A load is visible to a pixel in the very next
// cycle. channel_order may only be written while no pixel is in flight.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "palette_alpha_blend_blit_top_defines.svh"

module palette_alpha_blend_blit_top (
    input  logic        aclk,
    input  logic        aresetn,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // color_index, entry_red, entry_green, entry_blue,
                                   // entry_alpha, dest_byte0, dest_byte1, dest_byte2
    input  logic        s_tuser,   // command
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // out_byte0, out_byte1, out_byte2
    // Register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic                 s_accept;
    logic                 s_pixel;
    logic                 advance;
    logic                 cfg_write;
    logic [1:0]           order_reg;
    logic                 s1_valid_reg;
    logic [23:0]          s1_dest_reg;
    logic                 m_valid_reg;
    logic [23:0]          m_data_reg;
    logic [31:0]          pal_rd_data;
    pabb_pkg::pal_entry_t pal_entry;
    logic [23:0]          blend_result;

    // Register port, always ready
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[2] == pabb_pkg::REG_CHANNEL_ORDER);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            order_reg <= pabb_pkg::ORDER_RGB;
        end else if (cfg_write) begin
            order_reg <= pwdata[1:0];
        end
    end

    assign prdata = (paddr[2] == pabb_pkg::REG_CHANNEL_ORDER) ? {30'd0, order_reg} : 32'd0;

    // Handshake: output register frees, stage 1 moves on
    assign advance  = !m_valid_reg || m_tready;
    assign s_tready = !s1_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;
    assign s_pixel  = (s_tuser == pabb_pkg::CMD_PIXEL);

    // Palette: loads write, pixels read
    pabb_ram #(
        .WIDTH(32),
        .DEPTH(pabb_pkg::PAL_DEPTH)
    ) u_palette (
        .aclk    (aclk),
        .wr_en   (s_accept && !s_pixel),
        .wr_addr (s_tdata[pabb_pkg::PAL_AW-1:0]),
        .wr_data (s_tdata[39:8]),
        .rd_en   (s_accept && s_pixel),
        .rd_addr (s_tdata[pabb_pkg::PAL_AW-1:0]),
        .rd_data (pal_rd_data)
    );

    // Stage 1: hold the pixel while its palette entry is read
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_tready) begin
            s1_valid_reg <= s_accept && s_pixel;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept && s_pixel) begin
            s1_dest_reg <= s_tdata[63:40];
        end
    end

    assign pal_entry = pabb_pkg::pal_entry_t'(pal_rd_data);

    pabb_blend u_blend (
        .entry  (pal_entry),
        .dest   (s1_dest_reg),
        .order  (order_reg),
        .result (blend_result)
    );

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && s1_valid_reg) begin
            m_data_reg <= blend_result;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // A load never puts anything in stage 1
    `PABB_ASSERT(a_load_no_result, (s_accept && !s_pixel) |=> !s1_valid_reg, "load produced a result")
    // A pixel moving out of stage 1 shows up at the output
    `PABB_ASSERT(a_stage_to_out, (s1_valid_reg && advance) |=> m_tvalid, "pixel lost in stage 1")
    // Input stalls only when both stages are full
    `PABB_ASSERT(a_stall_full, !s_tready |-> (s1_valid_reg && m_tvalid && !m_tready), "bad stall")
    // Nothing is valid in the cycle after reset
    `PABB_ASSERT_ALWAYS(a_reset_empty, !$past(aresetn) |-> (!s1_valid_reg && !m_tvalid), "valid after reset")

endmodule
